@@ sv/pid_controller_clamped_defines.svh @@
// Assertion macros for the PID controller
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH
`ifndef SYNTHESIS
`define PCC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcc assertion failed");
`define PCC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMP(lbl, ante, cons)
`define PCC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/pcc_pkg.sv @@
package pcc_pkg;

   localparam int DATA_W    = 32;
   localparam int DT_W      = 31;
   localparam int PROD_W    = 66;
   localparam int ACC_W     = 68;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_KP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HI = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_HI = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_LO = 3'd7;

   typedef enum logic [1:0] {
      MUL_ERR_DT,
      MUL_KP_ERR,
      MUL_KI_INT,
      MUL_KD_RATE
   } mul_sel_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] kp;
      logic signed [DATA_W-1:0] ki;
      logic signed [DATA_W-1:0] kd;
      logic        [DT_W-1:0]   dt;
      logic signed [DATA_W-1:0] out_hi;
      logic signed [DATA_W-1:0] out_lo;
      logic signed [DATA_W-1:0] int_hi;
      logic signed [DATA_W-1:0] int_lo;
   } cfg_type;

   typedef struct packed {
      logic        err_load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        integ_upd;
      logic        div_load;
      logic        acc_load;
      logic        acc_add;
      logic        rate_load;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
         r = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = S32_MIN;
      end else begin
         r = S32_MAX;
      end
      return r;
   endfunction

   // high limit first, low limit wins when crossed
   function automatic logic signed [DATA_W-1:0] clamp_hl(input logic signed [DATA_W-1:0] v,
                                                         input logic signed [DATA_W-1:0] hi,
                                                         input logic signed [DATA_W-1:0] lo);
      logic signed [DATA_W-1:0] r;
      r = v;
      if (r > hi) begin
         r = hi;
      end
      if (r < lo) begin
         r = lo;
      end
      return r;
   endfunction

endpackage

@@ sv/pcc_csr.sv @@
module pcc_csr
   import pcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KP:     cfg_in.kp     = csr_wdata;
            CSR_KI:     cfg_in.ki     = csr_wdata;
            CSR_KD:     cfg_in.kd     = csr_wdata;
            CSR_DT:     cfg_in.dt     = csr_wdata[DT_W-1:0];
            CSR_OUT_HI: cfg_in.out_hi = csr_wdata;
            CSR_OUT_LO: cfg_in.out_lo = csr_wdata;
            CSR_INT_HI: cfg_in.int_hi = csr_wdata;
            CSR_INT_LO: cfg_in.int_lo = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp     <= '0;
         cfg_ff.ki     <= '0;
         cfg_ff.kd     <= '0;
         cfg_ff.dt     <= DT_W'(65536);
         cfg_ff.out_hi <= S32_MAX;
         cfg_ff.out_lo <= S32_MIN;
         cfg_ff.int_hi <= S32_MAX;
         cfg_ff.int_lo <= S32_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/pcc_ctrl.sv @@
module pcc_ctrl
   import pcc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_ERRDT = 9'b000000010,
      S_INTEG = 9'b000000100,
      S_KP    = 9'b000001000,
      S_KI    = 9'b000010000,
      S_DIVW  = 9'b000100000,
      S_KD    = 9'b001000000,
      S_ACC   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.err_load = 1'b1;
               state_in     = S_ERRDT;
            end
         end
         S_ERRDT: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_ERR_DT;
            cmd.div_load = 1'b1;
            state_in     = S_INTEG;
         end
         S_INTEG: begin
            cmd.integ_upd = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_KP_ERR;
            state_in      = S_KP;
         end
         S_KP: begin
            cmd.acc_load = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_KI_INT;
            state_in     = S_KI;
         end
         S_KI: begin
            cmd.acc_add = 1'b1;
            state_in    = S_DIVW;
         end
         S_DIVW: begin
            if (stat.div_done) begin
               cmd.rate_load = 1'b1;
               state_in      = S_KD;
            end
         end
         S_KD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_KD_RATE;
            state_in    = S_ACC;
         end
         S_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/pcc_dp.sv @@
module pcc_dp
   import pcc_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [DATA_W-1:0] setpoint,
   input  logic signed [DATA_W-1:0] measured,
   input  cfg_type                  cfg,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   output logic signed [DATA_W-1:0] drive
);

   localparam int QW    = DATA_W + FRAC_BITS;
   localparam int CNT_W = $clog2(QW + 1);

   logic signed [DATA_W-1:0] err_ff;
   logic signed [DATA_W-1:0] prev_ff;
   logic signed [DATA_W-1:0] integ_ff;
   logic signed [DATA_W-1:0] rate_ff;
   logic signed [DATA_W-1:0] drive_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [DT_W-1:0]          div_rem_ff;
   logic [QW-1:0]            div_quo_ff;
   logic [CNT_W-1:0]         div_cnt_ff;
   logic                     div_neg_ff;

   logic signed [DATA_W:0]   err_diff;
   logic [DT_W-1:0]          dt_eff;
   logic signed [DATA_W:0]   mul_a;
   logic signed [DATA_W:0]   mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [ACC_W-1:0]  prod_x;
   logic signed [ACC_W-1:0]  integ_sum;
   logic signed [DATA_W:0]   diff_d;
   logic [DATA_W:0]          diff_mag;
   logic [DT_W:0]            div_part;
   logic [DT_W+1:0]          div_trial;
   logic                     pos_ovf;
   logic                     neg_ovf;
   logic signed [DATA_W-1:0] rate_val;

   assign err_diff = {setpoint[DATA_W-1], setpoint} - {measured[DATA_W-1], measured};
   assign dt_eff   = (cfg.dt == '0) ? DT_W'(1) : cfg.dt;

   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR_DT: begin
            mul_a = {err_ff[DATA_W-1], err_ff};
            mul_b = $signed({2'b00, dt_eff});
         end
         MUL_KP_ERR: begin
            mul_a = {cfg.kp[DATA_W-1], cfg.kp};
            mul_b = {err_ff[DATA_W-1], err_ff};
         end
         MUL_KI_INT: begin
            mul_a = {cfg.ki[DATA_W-1], cfg.ki};
            mul_b = {integ_ff[DATA_W-1], integ_ff};
         end
         MUL_KD_RATE: begin
            mul_a = {cfg.kd[DATA_W-1], cfg.kd};
            mul_b = {rate_ff[DATA_W-1], rate_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p     = mul_a * mul_b;
   assign prod_sh   = prod_ff >>> FRAC_BITS;
   assign prod_x    = $signed({{(ACC_W-PROD_W){prod_sh[PROD_W-1]}}, prod_sh});
   assign integ_sum = $signed({{(ACC_W-DATA_W){integ_ff[DATA_W-1]}}, integ_ff}) + prod_x;

   // restoring divider on magnitudes, one quotient bit per cycle
   assign diff_d    = {err_ff[DATA_W-1], err_ff} - {prev_ff[DATA_W-1], prev_ff};
   assign diff_mag  = diff_d[DATA_W] ? -diff_d : diff_d;
   assign div_part  = {div_rem_ff, div_quo_ff[QW-1]};
   assign div_trial = {1'b0, div_part} - {2'b00, dt_eff};

   assign stat.div_done = (div_cnt_ff == '0);

   assign pos_ovf = |div_quo_ff[QW-1:DATA_W-1];
   assign neg_ovf = (|div_quo_ff[QW-1:DATA_W]) ||
                    (div_quo_ff[DATA_W-1] && (|div_quo_ff[DATA_W-2:0]));

   always_comb begin
      if (div_neg_ff) begin
         rate_val = neg_ovf ? S32_MIN : -div_quo_ff[DATA_W-1:0];
      end else begin
         rate_val = pos_ovf ? S32_MAX : div_quo_ff[DATA_W-1:0];
      end
   end

   assign drive = drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff   <= '0;
         prev_ff    <= '0;
         div_cnt_ff <= '0;
      end else begin
         if (cmd.integ_upd) begin
            integ_ff <= clamp_hl(sat32(integ_sum), cfg.int_hi, cfg.int_lo);
         end
         if (cmd.div_load) begin
            prev_ff    <= err_ff;
            div_cnt_ff <= CNT_W'(QW);
         end else if (!stat.div_done) begin
            div_cnt_ff <= div_cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.err_load) begin
         err_ff <= sat32($signed({{(ACC_W-DATA_W-1){err_diff[DATA_W]}}, err_diff}));
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_x;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_x;
      end
      if (cmd.div_load) begin
         div_rem_ff <= '0;
         div_quo_ff <= {diff_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
         div_neg_ff <= diff_d[DATA_W];
      end else if (!stat.div_done) begin
         if (!div_trial[DT_W+1]) begin
            div_rem_ff <= div_trial[DT_W-1:0];
            div_quo_ff <= {div_quo_ff[QW-2:0], 1'b1};
         end else begin
            div_rem_ff <= div_part[DT_W-1:0];
            div_quo_ff <= {div_quo_ff[QW-2:0], 1'b0};
         end
      end
      if (cmd.rate_load) begin
         rate_ff <= rate_val;
      end
      if (cmd.out_load) begin
         drive_ff <= clamp_hl(sat32(acc_ff), cfg.out_hi, cfg.out_lo);
      end
   end

endmodule

@@ sv/pid_controller_clamped.sv @@
// channel   dir  handshake             payload
// req       in   req_tvalid/tready     setpoint, measured
// rsp       out  rsp_tvalid/tready     drive
// csr       in   csr_valid/csr_ready   csr_index, csr_wdata
//
// One beat in, one beat out. A new beat is taken only after the previous
// beat's drive is loaded into the result register; the pace is set by the
// restoring divider for the derivative term (one bit of 32+FRAC_BITS a cycle).
// One multiplier is shared by the error*dt, kp, ki and kd products.
// The result register lets the next beat run while rsp is stalled.
// Synchronous active-high reset; csr_ready is always high.
`include "pid_controller_clamped_defines.svh"
module pid_controller_clamped
   import pcc_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,  // setpoint[31:0], measured[63:32]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,  // drive[31:0]
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   cfg_type                  cfg;
   cmd_type                  cmd;
   stat_type                 stat;
   logic signed [DATA_W-1:0] drive;

   pcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pcc_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .setpoint ($signed(req_tdata[31:0])),
      .measured ($signed(req_tdata[63:32])),
      .cfg      (cfg),
      .cmd      (cmd),
      .stat     (stat),
      .drive    (drive)
   );

   assign rsp_tdata = drive;

   `PCC_ASSERT_IMP(a_out_has_room, cmd.out_load, !rsp_tvalid || rsp_tready)
   `PCC_ASSERT_IMP(a_rate_after_div, cmd.rate_load, stat.div_done)
   `PCC_ASSERT_NXT(a_busy_after_beat, req_tvalid && req_tready, !req_tready)

endmodule

@@ dv/tb_pid_controller_clamped.sv @@
module tb_pid_controller_clamped
   import pcc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC        = 16;
   localparam int SETTLE_CYC  = FRAC + 40;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int PHASES      = 9;
   localparam int PHASE_BEATS = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata = '0;   // setpoint[31:0], measured[63:32]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;        // drive[31:0]
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0]     csr_wdata = '0;

   pid_controller_clamped #(.FRAC_BITS(FRAC)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // controller image: registers and loop state
   logic signed [31:0] gain_p = '0;
   logic signed [31:0] gain_i = '0;
   logic signed [31:0] gain_d = '0;
   logic        [30:0] step_reg = 31'd65536;
   logic signed [31:0] drive_hi = S32_MAX;
   logic signed [31:0] drive_lo = S32_MIN;
   logic signed [31:0] integ_hi = S32_MAX;
   logic signed [31:0] integ_lo = S32_MIN;
   logic signed [31:0] integ_acc = '0;
   logic signed [31:0] last_err = '0;

   logic [31:0] drive_q[$];
   logic [31:0] drive_exp;
   int          errors = 0;
   int          cycle_count = 0;
   int          hold_len = 0;
   int          rsp_stall = 0;
   bit          steady = 1'b0;

   function automatic logic signed [31:0] saturate_word(input longint v);
      if (v > longint'(S32_MAX)) return S32_MAX;
      if (v < longint'(S32_MIN)) return S32_MIN;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] limit_to(input logic signed [31:0] v,
                                                   input logic signed [31:0] hi,
                                                   input logic signed [31:0] lo);
      logic signed [31:0] r;
      r = v;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r;
   endfunction

   function automatic longint fx_product(input longint a, input longint b);
      longint p;
      p = a * b;
      return p >>> FRAC;
   endfunction

   function automatic logic [31:0] next_drive(input logic signed [31:0] sp,
                                              input logic signed [31:0] ms);
      longint             dt;
      longint             total;
      logic signed [31:0] err;
      logic signed [31:0] integ;
      logic signed [31:0] rate;
      dt = (step_reg == '0) ? 64'sd1 : longint'({33'b0, step_reg});
      err = saturate_word(longint'(sp) - longint'(ms));
      integ = saturate_word(longint'(integ_acc) + fx_product(longint'(err), dt));
      integ = limit_to(integ, integ_hi, integ_lo);
      rate = saturate_word(((longint'(err) - longint'(last_err)) * (64'sd1 <<< FRAC)) / dt);
      total = fx_product(longint'(gain_p), longint'(err))
            + fx_product(longint'(gain_i), longint'(integ))
            + fx_product(longint'(gain_d), longint'(rate));
      integ_acc = integ;
      last_err = err;
      return limit_to(saturate_word(total), drive_hi, drive_lo);
   endfunction

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return S32_MAX;
         1: return S32_MIN;
         2: return '0;
         3, 4, 5: return $urandom;
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_gain();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return S32_MAX;
         2: return S32_MIN;
         3: return '0;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_step();
      case ($urandom_range(0, 11))
         0: return $urandom;
         1: return 32'h0000_0000;
         2: return 32'h0000_0001;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         default: return {1'($urandom_range(0, 1)), 31'($urandom_range(256, 262144))};
      endcase
   endfunction

   // result side: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_tready <= 1'b0;
            hold_len--;
         end else if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else if (steady || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rsp_stall = next_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_q.size() == 0) begin
            errors++;
            $display("%0t: drive beat with none pending: actual %h", $time, rsp_tdata);
         end else begin
            drive_exp = drive_q.pop_front();
            if (rsp_tdata !== drive_exp) begin
               errors++;
               $display("%0t: drive mismatch: expected %h actual %h",
                        $time, drive_exp, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_sample(input logic signed [31:0] sp, input logic signed [31:0] ms);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {ms, sp};
      do @(posedge clock); while (!req_tready);
      drive_q.push_back(next_drive(sp, ms));
      gap = next_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KP:     gain_p   = val;
         CSR_KI:     gain_i   = val;
         CSR_KD:     gain_d   = val;
         CSR_DT:     step_reg = val[30:0];
         CSR_OUT_HI: drive_hi = val;
         CSR_OUT_LO: drive_lo = val;
         CSR_INT_HI: integ_hi = val;
         CSR_INT_LO: integ_lo = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait out every pending drive and the pipeline behind it
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic load_regs(input logic [31:0] kp, input logic [31:0] ki,
                            input logic [31:0] kd, input logic [31:0] dt,
                            input logic [31:0] ohi, input logic [31:0] olo,
                            input logic [31:0] ihi, input logic [31:0] ilo);
      settle();
      write_reg(CSR_KP, kp);
      write_reg(CSR_KI, ki);
      write_reg(CSR_KD, kd);
      write_reg(CSR_DT, dt);
      write_reg(CSR_OUT_HI, ohi);
      write_reg(CSR_OUT_LO, olo);
      write_reg(CSR_INT_HI, ihi);
      write_reg(CSR_INT_LO, ilo);
   endtask

   task automatic test_reset_defaults();
      send_sample(32'sh0003_0000, 32'sh0001_0000);
      send_sample(S32_MAX, S32_MIN);
   endtask

   // kp = 1.0, drive follows the saturated error
   task automatic test_error_extremes();
      load_regs(32'h0001_0000, '0, '0, 32'h0001_0000, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
      send_sample(S32_MAX, S32_MIN);
      send_sample(S32_MIN, S32_MAX);
      send_sample(S32_MIN, S32_MIN);
      send_sample(S32_MAX, S32_MAX);
      send_sample(-32'sd1, 32'sd0);
      send_sample(32'sd0, -32'sd1);
   endtask

   task automatic test_gain_extremes();
      load_regs(S32_MAX, S32_MIN, S32_MAX, 32'h0000_0001, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
      send_sample(S32_MAX, S32_MIN);
      send_sample(S32_MIN, S32_MAX);
      send_sample(32'sd0, 32'sd0);
   endtask

   // dt of zero acts as one LSB; bit 31 of the write is dropped
   task automatic test_zero_step();
      load_regs(32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000,
                S32_MAX, S32_MIN, 32'h0010_0000, 32'hFFF0_0000);
      send_sample(32'sh0000_0100, 32'sd0);
      send_sample(-32'sh0000_0100, 32'sd0);
      send_sample(32'sh0002_0000, 32'sh0001_0000);
      settle();
      write_reg(CSR_DT, 32'h8000_0000);
      send_sample(32'sh0000_0005, 32'sh0000_0007);
   endtask

   // low limits above high limits: low wins
   task automatic test_crossed_limits();
      load_regs(32'h0001_0000, 32'h0001_0000, '0, 32'h0001_0000,
                32'hFFFB_0000, 32'h0005_0000, 32'hFFFF_0000, 32'h0001_0000);
      send_sample(32'sh0100_0000, 32'sd0);
      send_sample(-32'sh0100_0000, 32'sd0);
      send_sample(32'sd0, 32'sd0);
   endtask

   task automatic test_integral_clamp();
      load_regs('0, 32'h0001_0000, '0, 32'h0001_0000,
                32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000, 32'hFFFE_0000);
      repeat (3) send_sample(32'sh0001_0000, 32'sd0);
      send_sample(-32'sh0008_0000, 32'sd0);
   endtask

   task automatic send_random_sample();
      logic signed [31:0] sp;
      logic signed [31:0] ms;
      sp = rand_word();
      if ($urandom_range(0, 3) == 0)
         ms = rand_word();
      else
         ms = sp + $signed(32'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      send_sample(sp, ms);
   endtask

   task automatic test_output_hold_off();
      settle();
      steady = 1'b1;
      @(posedge clock);
      hold_len = 1500;
      repeat (12) send_random_sample();
      steady = 1'b0;
   endtask

   task automatic test_random_tuning();
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
      for (int phase = 0; phase < PHASES; phase++) begin
         a = rand_word();
         b = rand_word();
         c = rand_word();
         d = rand_word();
         if ($urandom_range(0, 4) != 0 && a < b) begin
            a = b;
            b = rand_word() & 32'h8000_0000 ? a - 32'($urandom) : b;
         end
         if ($urandom_range(0, 4) != 0 && c < d) begin
            c = d;
            d = S32_MIN;
         end
         if (phase % 3 == 0) begin
            a = S32_MAX;
            b = S32_MIN;
         end
         load_regs(rand_gain(), rand_gain(), rand_gain(), rand_step(), a, b, c, d);
         steady = (phase % 4 == 1);
         repeat (PHASE_BEATS) send_random_sample();
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_error_extremes();
      test_gain_extremes();
      test_zero_step();
      test_crossed_limits();
      test_integral_clamp();
      test_output_hold_off();
      test_random_tuning();
      settle();
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ pid_controller_clamped.f @@
+incdir+sv
sv/pcc_pkg.sv
sv/pcc_csr.sv
sv/pcc_ctrl.sv
sv/pcc_dp.sv
sv/pid_controller_clamped.sv
dv/tb_pid_controller_clamped.sv
